FILE: hw/rtl/ctt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types, constants and helpers of the configurable text tokenizer.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int unsigned SYM_W              = 56;
  localparam int unsigned SYM_BYTES_W        = 3;
  localparam int unsigned TOK_BYTES_W        = 6;
  localparam int unsigned IN_TDATA_W         = 8;
  localparam int unsigned OUT_TDATA_W        = 72;
  localparam int unsigned OUT_TUSER_W        = 2;
  localparam int unsigned CFG_IDX_W          = 3;
  localparam int unsigned CFG_DATA_W         = 64;
  localparam int unsigned IGNORE_SLOTS       = 8;
  localparam int unsigned MAX_SYMBOL_BYTES   = 7;
  localparam int unsigned TOKEN_CAPACITY_DEF = 50;
  localparam int unsigned GROUP_DEPTH        = 4;
  localparam int unsigned GROUP_PTR_W        = $clog2(GROUP_DEPTH);
  localparam int unsigned GROUP_CNT_W        = $clog2(GROUP_DEPTH + 1);

  localparam logic [SYM_W-1:0] SYM_CR = SYM_W'(13);
  localparam logic [SYM_W-1:0] SYM_LF = SYM_W'(10);

  localparam logic [SYM_W-1:0]      LINE_BREAK_RST   = SYM_W'(10);
  localparam logic [SYM_W-1:0]      TOKEN_BREAK_RST  = SYM_W'(32);
  localparam logic [SYM_W-1:0]      COMMENT_RST      = SYM_W'(35);
  localparam logic [SYM_W-1:0]      ESCAPE_RST       = SYM_W'(92);
  localparam logic [SYM_W-1:0]      QUOTE_RST        = SYM_W'(34);
  localparam logic [SYM_W-1:0]      CONTINUATION_RST = SYM_W'(0);
  localparam logic [CFG_DATA_W-1:0] IGNORE_SET_RST   = CFG_DATA_W'(0);

  typedef enum logic [OUT_TUSER_W-1:0] {
    EV_APPEND      = 2'd0,
    EV_CODE_END    = 2'd1,
    EV_COMMENT_END = 2'd2,
    EV_LINE_END    = 2'd3
  } event_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_BREAK   = 3'd0,
    REG_TOKEN_BREAK  = 3'd1,
    REG_COMMENT      = 3'd2,
    REG_ESCAPE       = 3'd3,
    REG_QUOTE        = 3'd4,
    REG_CONTINUATION = 3'd5,
    REG_IGNORE_SET   = 3'd6
  } cfg_reg_e;

  // events raised by one request, in delivery order
  typedef struct packed {
    logic                   has_app;
    logic [SYM_W-1:0]       sym;
    logic [SYM_BYTES_W-1:0] len;
    logic                   has_tok;
    logic                   tok_comment;
    logic [TOK_BYTES_W-1:0] tbytes;
    logic                   has_line;
  } group_t;

  function automatic logic [SYM_BYTES_W-1:0] lead_length(input logic [7:0] b);
    logic [SYM_BYTES_W-1:0] len;
    if (b < 8'h80) begin
      len = 3'd1;
    end else if (b < 8'hE0) begin
      len = 3'd2;
    end else if (b < 8'hF0) begin
      len = 3'd3;
    end else if (b < 8'hF8) begin
      len = 3'd4;
    end else if (b < 8'hFC) begin
      len = 3'd5;
    end else if (b < 8'hFE) begin
      len = 3'd6;
    end else begin
      len = 3'd7;
    end
    if (len > SYM_BYTES_W'(MAX_SYMBOL_BYTES)) begin
      len = SYM_BYTES_W'(MAX_SYMBOL_BYTES);
    end
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/configurable_text_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// configurable_text_tokenizer
// Packs text bytes into symbols and reports append, token-end and line-end
// events.
// ----------------------------------------------------------------------------
// One byte request is taken per cycle. A request that completes a symbol, or
// a flush, raises up to three events (append, token end, line end); these are
// stored together in a four-entry event queue and leave one per cycle while
// tready is high, tlast marking each request's last event. Input is refused
// only while that queue is full, so throughput is one byte per cycle as long
// as output events do not outnumber input bytes and tready is high; else the
// queue drain rate of one event per cycle sets the limit. Configuration is
// always accepted and must be written while the block is idle.
module configurable_text_tokenizer #(
  parameter int unsigned TokenCapacity = ctt_pkg::TOKEN_CAPACITY_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  wire logic [ctt_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic                               s_axis_tuser_i,   // [0] flush
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // [55:0] symbol_value, [58:56] symbol_bytes, [64:59] token_bytes, rest zero
  output logic [ctt_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o,
  output logic [ctt_pkg::OUT_TUSER_W-1:0]         m_axis_tuser_o,   // [1:0] event_kind
  output logic                                    m_axis_tlast_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [ctt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [ctt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ctt_pkg::*;

  localparam int unsigned TLW = $clog2(TokenCapacity + 1);

  logic [SYM_W-1:0]      line_break_q, token_break_q, comment_q, escape_q;
  logic [SYM_W-1:0]      quote_q, continuation_q;
  logic [CFG_DATA_W-1:0] ignore_set_q;

  logic [SYM_W-1:0]       buf_q, buf_d;
  logic [SYM_BYTES_W-1:0] coll_q, coll_d, exp_q, exp_d;
  logic [SYM_W-1:0]       prev_q, prev_d;
  logic [TLW-1:0]         tl_q, tl_d;
  logic                   comm_q, comm_d, supp_q, supp_d, cont_q, cont_d;

  group_t                 gq_q [GROUP_DEPTH];
  logic [GROUP_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [GROUP_CNT_W-1:0] count_q;
  logic [1:0]             sent_q;

  logic                   s_fire, m_fire, push, pop;
  group_t                 grp, head;
  logic [SYM_BYTES_W-1:0] lead, exp_len, coll_inc;
  logic [SYM_W-1:0]       base, sym;
  logic                   complete;
  logic                   is_break, is_line, esc_sym, escaped, live, ign, add, app;
  logic                   supp1, comm1, cont1, tok_cond;
  logic [TLW:0]           tl_sum;
  logic [TLW-1:0]         tl1;
  logic                   p_app, p_tok, cur_last;
  event_kind_e            cur_kind;
  logic [7:0]             ign_byte;
  logic                   ign_open;

  assign s_fire      = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire      = m_axis_tvalid_o && m_axis_tready_i;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_break_q   <= LINE_BREAK_RST;
      token_break_q  <= TOKEN_BREAK_RST;
      comment_q      <= COMMENT_RST;
      escape_q       <= ESCAPE_RST;
      quote_q        <= QUOTE_RST;
      continuation_q <= CONTINUATION_RST;
      ignore_set_q   <= IGNORE_SET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LINE_BREAK:   line_break_q   <= cfg_data_i[SYM_W-1:0];
        REG_TOKEN_BREAK:  token_break_q  <= cfg_data_i[SYM_W-1:0];
        REG_COMMENT:      comment_q      <= cfg_data_i[SYM_W-1:0];
        REG_ESCAPE:       escape_q       <= cfg_data_i[SYM_W-1:0];
        REG_QUOTE:        quote_q        <= cfg_data_i[SYM_W-1:0];
        REG_CONTINUATION: continuation_q <= cfg_data_i[SYM_W-1:0];
        REG_IGNORE_SET:   ignore_set_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    lead     = lead_length(s_axis_tdata_i);
    exp_len  = (coll_q == '0) ? lead : exp_q;
    base     = (coll_q == '0) ? '0 : buf_q;
    sym      = base;
    for (int k = 0; k < MAX_SYMBOL_BYTES; k++) begin
      if (coll_q == SYM_BYTES_W'(k)) begin
        sym[8*k +: 8] = s_axis_tdata_i;
      end
    end
    coll_inc = coll_q + 3'd1;
    complete = coll_inc >= exp_len;

    is_break = sym == token_break_q;
    is_line  = (sym == line_break_q) || (sym == SYM_CR) || (sym == SYM_LF);
    esc_sym  = sym == escape_q;
    escaped  = (prev_q == escape_q) && !esc_sym;
    live     = !escaped && !comm_q;

    ign      = 1'b0;
    ign_open = 1'b1;
    for (int i = 0; i < IGNORE_SLOTS; i++) begin
      ign_byte = ignore_set_q[8*i +: 8];
      if (ign_byte == 8'd0) begin
        ign_open = 1'b0;
      end
      if (ign_open && (sym == SYM_W'(ign_byte))) begin
        ign = 1'b1;
      end
    end

    add = !((live && is_break && !supp_q) || (live && (sym == continuation_q)) ||
            (live && esc_sym) || (live && (sym == quote_q)) ||
            (live && (sym == comment_q)) || (!escaped && (sym == line_break_q)) || ign);

    tl_sum   = {1'b0, tl_q} + (TLW+1)'(exp_len);
    app      = add && (tl_sum <= (TLW+1)'(TokenCapacity));
    tl1      = app ? tl_sum[TLW-1:0] : tl_q;
    supp1    = (live && (sym == quote_q)) ? !supp_q : supp_q;
    comm1    = comm_q || (live && (sym == comment_q));
    cont1    = cont_q || (live && (sym == continuation_q));
    tok_cond = (!supp1 && is_break) || (is_line && (tl1 != '0));

    buf_d  = buf_q;
    coll_d = coll_q;
    exp_d  = exp_q;
    prev_d = prev_q;
    tl_d   = tl_q;
    comm_d = comm_q;
    supp_d = supp_q;
    cont_d = cont_q;
    grp    = '0;

    if (s_fire) begin
      if (s_axis_tuser_i) begin
        grp.has_tok     = tl_q != '0;
        grp.tok_comment = comm_q;
        grp.tbytes      = TOK_BYTES_W'(tl_q);
        buf_d  = '0;
        coll_d = '0;
        exp_d  = '0;
        prev_d = '0;
        tl_d   = '0;
        comm_d = 1'b0;
        supp_d = 1'b0;
        cont_d = 1'b0;
      end else if (!complete) begin
        buf_d  = sym;
        coll_d = coll_inc;
        exp_d  = exp_len;
      end else begin
        buf_d           = '0;
        coll_d          = '0;
        exp_d           = '0;
        grp.has_app     = app;
        grp.sym         = sym;
        grp.len         = exp_len;
        grp.has_tok     = tok_cond && (tl1 != '0);
        grp.tok_comment = comm1;
        grp.tbytes      = TOK_BYTES_W'(tl1);
        grp.has_line    = is_line && !cont1;
        tl_d            = tok_cond ? '0 : tl1;
        comm_d          = comm1;
        supp_d          = supp1;
        cont_d          = cont1;
        if (is_line) begin
          cont_d = 1'b0;
          if (!cont1) begin
            comm_d = 1'b0;
            supp_d = 1'b0;
          end
        end
        prev_d = sym;
      end
    end
    push = grp.has_app || grp.has_tok || grp.has_line;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      coll_q <= '0;
      exp_q  <= '0;
      prev_q <= '0;
      tl_q   <= '0;
      comm_q <= 1'b0;
      supp_q <= 1'b0;
      cont_q <= 1'b0;
    end else begin
      buf_q  <= buf_d;
      coll_q <= coll_d;
      exp_q  <= exp_d;
      prev_q <= prev_d;
      tl_q   <= tl_d;
      comm_q <= comm_d;
      supp_q <= supp_d;
      cont_q <= cont_d;
    end
  end

  // event queue
  assign head            = gq_q[rd_ptr_q];
  assign s_axis_tready_o = count_q != GROUP_CNT_W'(GROUP_DEPTH);
  assign m_axis_tvalid_o = count_q != '0;

  always_comb begin
    p_app = head.has_app && !sent_q[0];
    p_tok = head.has_tok && !sent_q[1];
    if (p_app) begin
      cur_kind = EV_APPEND;
      cur_last = !head.has_tok && !head.has_line;
    end else if (p_tok) begin
      cur_kind = head.tok_comment ? EV_COMMENT_END : EV_CODE_END;
      cur_last = !head.has_line;
    end else begin
      cur_kind = EV_LINE_END;
      cur_last = 1'b1;
    end
    m_axis_tdata_o = '0;
    if (p_app) begin
      m_axis_tdata_o[SYM_W-1:0]                     = head.sym;
      m_axis_tdata_o[SYM_W +: SYM_BYTES_W]          = head.len;
    end else if (p_tok) begin
      m_axis_tdata_o[SYM_W+SYM_BYTES_W +: TOK_BYTES_W] = head.tbytes;
    end
    m_axis_tuser_o = cur_kind;
    m_axis_tlast_o = cur_last;
  end

  assign pop = m_fire && cur_last;

  always_ff @(posedge clk_i) begin
    if (push) begin
      gq_q[wr_ptr_q] <= grp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      sent_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + GROUP_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + GROUP_PTR_W'(1);
        sent_q   <= '0;
      end else if (m_fire) begin
        if (p_app) begin
          sent_q[0] <= 1'b1;
        end else begin
          sent_q[1] <= 1'b1;
        end
      end
      if (push && !pop) begin
        count_q <= count_q + GROUP_CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - GROUP_CNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= GROUP_CNT_W'(GROUP_DEPTH))
    else $error("event queue count beyond depth");

  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (head.has_app || head.has_tok || head.has_line))
    else $error("queued request carries no event");

  a_token_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, tl_q} <= (TLW+1)'(TokenCapacity))
    else $error("token length beyond capacity");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser_i) |=> (tl_q == '0 && coll_q == '0 && !comm_q && !cont_q))
    else $error("flush left state behind");
`endif

endmodule
`default_nettype wire

FILE: tb/ctt_event_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_event_checker
// Watches the byte, event and register channels of the tokenizer. Each
// accepted request is run through a local model of the tokenizer and the
// events it raises are queued. Each delivered event is compared, field by
// field, with the oldest queued one.
// ----------------------------------------------------------------------------
module ctt_event_checker
  import ctt_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_ready_i,
  input  wire logic [IN_TDATA_W-1:0]  in_data_i,   // [7:0] data_byte
  input  wire logic                   in_flush_i,  // [0] flush
  input  wire logic                   out_valid_i,
  input  wire logic                   out_ready_i,
  // [55:0] symbol_value, [58:56] symbol_bytes, [64:59] token_bytes, rest zero
  input  wire logic [OUT_TDATA_W-1:0] out_data_i,
  input  wire logic [OUT_TUSER_W-1:0] out_kind_i,  // [1:0] event_kind
  input  wire logic                   out_last_i,
  input  wire logic                   cfg_valid_i,
  input  wire logic                   cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o,
  output int unsigned                 event_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAD_LSB = SYM_W + SYM_BYTES_W + TOK_BYTES_W;

  typedef struct packed {
    event_kind_e            kind;
    logic [SYM_W-1:0]       sym;
    logic [SYM_BYTES_W-1:0] sbytes;
    logic [TOK_BYTES_W-1:0] tbytes;
    logic                   last;
  } tok_event_t;

  tok_event_t expected_events[$];

  logic [SYM_W-1:0]      line_brk, tok_brk, cmt_sym, esc_sym, quote_sym, cont_sym;
  logic [CFG_DATA_W-1:0] ignore_bytes;

  logic [SYM_W-1:0] asm_buf, prev_sym;
  int unsigned      got_bytes, need_bytes, tok_len;
  bit               in_cmt, quoted, cont_pend;
  int unsigned      fails, events;

  task automatic clear_tokenizer();
    asm_buf    = '0;
    prev_sym   = '0;
    got_bytes  = 0;
    need_bytes = 0;
    tok_len    = 0;
    in_cmt     = 1'b0;
    quoted     = 1'b0;
    cont_pend  = 1'b0;
  endtask

  // leading ones of the lead byte decide the symbol size
  function automatic int unsigned symbol_size(input logic [7:0] lead);
    int unsigned ones, n;
    ones = 0;
    while (ones < 8 && lead[7-ones]) ones++;
    n = (ones <= 1) ? ones + 1 : (ones == 2 ? 2 : ones);
    if (n > 7) n = 7;
    if (n > MAX_SYMBOL_BYTES) n = MAX_SYMBOL_BYTES;
    return n;
  endfunction

  function automatic bit is_ignored(input logic [SYM_W-1:0] sym);
    logic [7:0] b;
    for (int unsigned i = 0; i < IGNORE_SLOTS; i++) begin
      b = ignore_bytes[8*i +: 8];
      if (b == 8'h00) return 1'b0;
      if (sym == SYM_W'(b)) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic push_event(input event_kind_e kind, input logic [SYM_W-1:0] sym,
                            input int unsigned sbytes, input int unsigned tbytes);
    tok_event_t ev;
    ev.kind   = kind;
    ev.sym    = sym;
    ev.sbytes = SYM_BYTES_W'(sbytes);
    ev.tbytes = TOK_BYTES_W'(tbytes);
    ev.last   = 1'b0;
    expected_events.push_back(ev);
  endtask

  task automatic end_token();
    if (tok_len != 0) push_event(in_cmt ? EV_COMMENT_END : EV_CODE_END, '0, 0, tok_len);
    tok_len = 0;
  endtask

  task automatic tokenize_symbol(input logic [SYM_W-1:0] sym, input int unsigned n);
    bit brk, eol, esc, live, keep;
    brk  = (sym == tok_brk);
    eol  = (sym == line_brk) || (sym == SYM_CR) || (sym == SYM_LF);
    esc  = (prev_sym == esc_sym) && (sym != esc_sym);
    live = !esc && !in_cmt;
    keep = 1'b1;
    if (live && brk && !quoted) keep = 1'b0;
    if (live && sym == cont_sym) begin
      cont_pend = 1'b1;
      keep      = 1'b0;
    end
    if (live && sym == esc_sym) keep = 1'b0;
    if (live && sym == quote_sym) begin
      quoted = !quoted;
      keep   = 1'b0;
    end
    if (live && sym == cmt_sym) begin
      in_cmt = 1'b1;
      keep   = 1'b0;
    end
    if (!esc && sym == line_brk) keep = 1'b0;
    if (keep && is_ignored(sym)) keep = 1'b0;
    if (keep && tok_len + n <= TOKEN_CAPACITY_DEF) begin
      tok_len += n;
      push_event(EV_APPEND, sym, n, 0);
    end
    if ((!quoted && brk) || (eol && tok_len != 0)) end_token();
    if (eol) begin
      if (!cont_pend) begin
        push_event(EV_LINE_END, '0, 0, 0);
        in_cmt = 1'b0;
        quoted = 1'b0;
      end
      cont_pend = 1'b0;
    end
    prev_sym = sym;
  endtask

  task automatic predict_request(input logic [7:0] b, input logic flush);
    int unsigned      size_at_start, n;
    logic [SYM_W-1:0] sym;
    tok_event_t       ev;
    size_at_start = expected_events.size();
    if (flush) begin
      end_token();
      clear_tokenizer();
    end else begin
      if (got_bytes == 0) begin
        need_bytes = symbol_size(b);
        asm_buf    = '0;
      end
      asm_buf[8*got_bytes +: 8] = b;
      got_bytes++;
      if (got_bytes >= need_bytes) begin
        sym        = asm_buf;
        n          = need_bytes;
        asm_buf    = '0;
        got_bytes  = 0;
        need_bytes = 0;
        tokenize_symbol(sym, n);
      end
    end
    if (expected_events.size() > size_at_start) begin
      ev      = expected_events.pop_back();
      ev.last = 1'b1;
      expected_events.push_back(ev);
    end
  endtask

  task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_LINE_BREAK:   line_brk     = val[SYM_W-1:0];
      REG_TOKEN_BREAK:  tok_brk      = val[SYM_W-1:0];
      REG_COMMENT:      cmt_sym      = val[SYM_W-1:0];
      REG_ESCAPE:       esc_sym      = val[SYM_W-1:0];
      REG_QUOTE:        quote_sym    = val[SYM_W-1:0];
      REG_CONTINUATION: cont_sym     = val[SYM_W-1:0];
      REG_IGNORE_SET:   ignore_bytes = val;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_event();
    tok_event_t want;
    events++;
    if (expected_events.size() == 0) begin
      fails++;
      $display("%0t: unexpected event, expected none, actual kind %0d tdata %h last %b",
               $time, out_kind_i, out_data_i, out_last_i);
    end else begin
      want = expected_events.pop_front();
      check_field("event_kind", 64'(want.kind), 64'(out_kind_i));
      check_field("symbol_value", 64'(want.sym), 64'(out_data_i[SYM_W-1:0]));
      check_field("symbol_bytes", 64'(want.sbytes), 64'(out_data_i[SYM_W +: SYM_BYTES_W]));
      check_field("token_bytes", 64'(want.tbytes),
                  64'(out_data_i[SYM_W+SYM_BYTES_W +: TOK_BYTES_W]));
      check_field("tdata padding", 64'd0, 64'(out_data_i[OUT_TDATA_W-1:PAD_LSB]));
      check_field("tlast", 64'(want.last), 64'(out_last_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_brk     = LINE_BREAK_RST;
      tok_brk      = TOKEN_BREAK_RST;
      cmt_sym      = COMMENT_RST;
      esc_sym      = ESCAPE_RST;
      quote_sym    = QUOTE_RST;
      cont_sym     = CONTINUATION_RST;
      ignore_bytes = IGNORE_SET_RST;
      clear_tokenizer();
      expected_events.delete();
      fails  = 0;
      events = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_event();
      if (cfg_valid_i && cfg_ready_i) load_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) predict_request(in_data_i, in_flush_i);
    end
    fail_count_o  <= fails;
    event_count_o <= events;
    pending_o     <= expected_events.size();
  end

endmodule
`default_nettype wire

FILE: tb/tb_configurable_text_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_configurable_text_tokenizer
// Drives byte and flush requests and register writes into the tokenizer
// under several register settings and idle patterns; an event checker beside
// the block predicts and compares every event.
// ----------------------------------------------------------------------------
module tb_configurable_text_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import ctt_pkg::*;

  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int unsigned SCRIPT_LEN    = 25;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                   s_axis_tuser_i  = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [OUT_TUSER_W-1:0] m_axis_tuser_o;
  logic                   m_axis_tlast_o;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i      = '0;

  int unsigned fail_count, pending, event_count;
  int unsigned req_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_left   = 0;
  bit          hold_toggle = 1'b0;
  bit          hold_seen   = 1'b0;

  logic [CFG_DATA_W-1:0] reg_image [0:7];
  int unsigned           reg_image_count;
  logic [SYM_W-1:0]      spec_sym [0:5];
  int unsigned           spec_len [0:5];
  int unsigned           ign_count, ign_len;

  configurable_text_tokenizer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  ctt_event_checker u_event_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_i    (s_axis_tready_o),
    .in_data_i     (s_axis_tdata_i),
    .in_flush_i    (s_axis_tuser_i),
    .out_valid_i   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_data_i    (m_axis_tdata_o),
    .out_kind_i    (m_axis_tuser_o),
    .out_last_i    (m_axis_tlast_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .event_count_o (event_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // hold off for a long stretch on request, else stall at random
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen       <= hold_toggle;
      hold_left       <= HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic flush);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'($urandom);
      s_axis_tuser_i  <= 1'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= flush;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    req_count++;
  endtask

  task automatic send_symbol(input logic [SYM_W-1:0] sym, input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) send_item(sym[8*i +: 8], 1'b0);
  endtask

  // lead byte drawn from the range that gives n bytes, tail bytes free
  function automatic logic [SYM_W-1:0] make_symbol(input int unsigned n);
    logic [SYM_W-1:0] sym;
    logic [7:0]       lo, hi;
    int unsigned      i;
    case (n)
      1: begin lo = 8'h00; hi = 8'h7F; end
      2: begin lo = 8'h80; hi = 8'hDF; end
      3: begin lo = 8'hE0; hi = 8'hEF; end
      4: begin lo = 8'hF0; hi = 8'hF7; end
      5: begin lo = 8'hF8; hi = 8'hFB; end
      6: begin lo = 8'hFC; hi = 8'hFD; end
      default: begin lo = 8'hFE; hi = 8'hFF; end
    endcase
    sym      = '0;
    sym[7:0] = 8'($urandom_range(hi, lo));
    for (i = 1; i < n; i++) sym[8*i +: 8] = 8'($urandom);
    return sym;
  endfunction

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs();
    int unsigned r;
    for (r = 0; r < reg_image_count; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(r);
      cfg_data_i  <= reg_image[r];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic pick_random_settings();
    int unsigned r, n;
    for (r = REG_LINE_BREAK; r <= REG_CONTINUATION; r++) begin
      n            = ($urandom_range(1) == 0) ? 1 : $urandom_range(7, 2);
      spec_len[r]  = n;
      spec_sym[r]  = make_symbol(n);
      reg_image[r] = {8'($urandom), spec_sym[r]};
    end
    ign_count = $urandom_range(8);
    ign_len   = 1;
    for (r = 0; r < 8; r++) begin
      if (r < ign_count) reg_image[REG_IGNORE_SET][8*r +: 8] = 8'($urandom_range(8'h7F, 8'h01));
      else if (r == ign_count) reg_image[REG_IGNORE_SET][8*r +: 8] = 8'h00;
      else reg_image[REG_IGNORE_SET][8*r +: 8] = 8'($urandom);
    end
    reg_image_count = 7;
  endtask

  task automatic pick_extreme_settings();
    spec_sym[REG_LINE_BREAK]   = '0;
    spec_sym[REG_TOKEN_BREAK]  = '1;
    spec_sym[REG_COMMENT]      = SYM_W'(8'hFE);
    spec_sym[REG_ESCAPE]       = SYM_W'(8'h7F);
    spec_sym[REG_QUOTE]        = SYM_W'(16'hBF80);
    spec_sym[REG_CONTINUATION] = {{6{8'hFF}}, 8'hFE};
    spec_len[REG_LINE_BREAK]   = 1;
    spec_len[REG_TOKEN_BREAK]  = 7;
    spec_len[REG_COMMENT]      = 7;
    spec_len[REG_ESCAPE]       = 1;
    spec_len[REG_QUOTE]        = 2;
    spec_len[REG_CONTINUATION] = 7;
    for (int unsigned r = REG_LINE_BREAK; r <= REG_CONTINUATION; r++)
      reg_image[r] = {8'hFF, spec_sym[r]};
    reg_image[REG_IGNORE_SET] = '1;
    reg_image[7]              = {$urandom, $urandom};
    ign_count       = 8;
    ign_len         = 7;
    reg_image_count = 8;
  endtask

  task automatic play_long_word();
    int unsigned i, n;
    n = $urandom_range(58, 48);
    for (i = 0; i < n; i++) send_item(8'($urandom_range(8'h7A, 8'h61)), 1'b0);
  endtask

  task automatic play_directed();
    logic [8:0]  script [0:SCRIPT_LEN-1];
    int unsigned i;
    script = '{9'h000, 9'h061, 9'h05C, 9'h022, 9'h022, 9'h020, 9'h022, 9'h023, 9'h078,
               9'h00D, 9'h0C3, 9'h0A9, 9'h020, 9'h00A, 9'h0FE, 9'h001, 9'h100,
               9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF};
    for (i = 0; i < SCRIPT_LEN; i++) send_item(script[i][7:0], script[i][8]);
  endtask

  task automatic play_text(input int unsigned n_items);
    int unsigned      stop_at, pick, n, k;
    logic [SYM_W-1:0] sym;
    stop_at = req_count + n_items;
    while (req_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 9) begin
        send_symbol(spec_sym[REG_TOKEN_BREAK], spec_len[REG_TOKEN_BREAK]);
      end else if (pick < 15) begin
        case ($urandom_range(2))
          0: send_symbol(spec_sym[REG_LINE_BREAK], spec_len[REG_LINE_BREAK]);
          1: send_item(SYM_CR[7:0], 1'b0);
          default: send_item(SYM_LF[7:0], 1'b0);
        endcase
      end else if (pick < 19) begin
        send_symbol(spec_sym[REG_COMMENT], spec_len[REG_COMMENT]);
      end else if (pick < 24) begin
        send_symbol(spec_sym[REG_ESCAPE], spec_len[REG_ESCAPE]);
      end else if (pick < 28) begin
        send_symbol(spec_sym[REG_QUOTE], spec_len[REG_QUOTE]);
      end else if (pick < 31) begin
        send_symbol(spec_sym[REG_CONTINUATION], spec_len[REG_CONTINUATION]);
      end else if (pick < 36) begin
        if (ign_count == 0) begin
          send_item(8'($urandom_range(8'h7E, 8'h21)), 1'b0);
        end else begin
          k = $urandom_range(ign_count - 1);
          send_symbol(SYM_W'(reg_image[REG_IGNORE_SET][8*k +: 8]), ign_len);
        end
      end else if (pick < 39) begin
        send_item(8'($urandom), 1'b0);
      end else if (pick < 41) begin
        send_item(8'($urandom), 1'b1);
      end else if (pick < 43) begin
        n   = $urandom_range(7, 2);
        sym = make_symbol(n);
        send_symbol(sym, $urandom_range(n - 1, 1));
        send_item(8'($urandom), 1'b1);
      end else if (pick < 45) begin
        play_long_word();
      end else if ($urandom_range(9) < 7) begin
        send_item(8'($urandom_range(8'h7E, 8'h21)), 1'b0);
      end else begin
        n = $urandom_range(7, 1);
        send_symbol(make_symbol(n), n);
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 12;
    rx_idle_pct <= 60;
    play_directed();
    drain();

    pick_random_settings();
    program_regs();
    play_long_word();
    play_text(75);
    drain();

    pick_extreme_settings();
    program_regs();
    tx_idle_pct = 60;
    rx_idle_pct <= 12;
    play_text(75);
    drain();

    pick_random_settings();
    program_regs();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_toggle <= ~hold_toggle;
    play_text(50);
    drain();
    play_text(50);
    drain();

    $display("run covered %0d byte and flush requests under four register settings,",
             req_count);
    $display("with %0d events checked, a long output hold-off and a full drain pause",
             event_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
hw/rtl/ctt_pkg.sv
hw/rtl/configurable_text_tokenizer.sv
tb/ctt_event_checker.sv
tb/tb_configurable_text_tokenizer.sv
